// ===== sv/ipsm_pkg.sv =====
`default_nettype none

package ipsm_pkg;

    localparam int NET_ENTRIES  = 256;
    localparam int HOST_ENTRIES = 256;

    localparam int NET_CNT_W  = $clog2(NET_ENTRIES + 1);
    localparam int HOST_CNT_W = $clog2(HOST_ENTRIES + 1);

    localparam int LOOK_CYCLES = (NET_ENTRIES > HOST_ENTRIES) ? NET_ENTRIES : HOST_ENTRIES;
    localparam int LOOK_W      = $clog2(LOOK_CYCLES + 1);

    // counter value during which each chain's tail holds the probe
    localparam int NET_CAP  = LOOK_CYCLES - NET_ENTRIES;
    localparam int HOST_CAP = LOOK_CYCLES - HOST_ENTRIES;

    localparam logic [1:0] CMD_ADD_NET  = 2'd0;
    localparam logic [1:0] CMD_ADD_HOST = 2'd1;
    localparam logic [1:0] CMD_LOOKUP   = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] address;
        logic [31:0] mask_bits;
    } t_in;

    typedef struct packed {
        logic hit;
        logic status;
    } t_out;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] keep;
    } t_entry;

    typedef struct packed {
        logic [31:0] key;
        logic        hit;
    } t_probe;

    typedef struct packed {
        logic add_net;
        logic add_host;
        logic imm_ack;
        logic cap_net;
        logic cap_host;
        logic finish;
    } t_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/ipsm_cell.sv =====
`default_nettype none

module ipsm_cell (
    input  wire logic            i_clk,
    input  wire logic            i_shift,
    input  wire logic            i_valid,
    input  wire ipsm_pkg::t_entry i_entry,
    output ipsm_pkg::t_entry     o_entry,
    input  wire ipsm_pkg::t_probe i_probe,
    output ipsm_pkg::t_probe     o_probe
);

    ipsm_pkg::t_entry r_entry;
    ipsm_pkg::t_probe r_probe;
    ipsm_pkg::t_probe n_probe;

    always_comb begin
        n_probe.key = i_probe.key;
        n_probe.hit = i_probe.hit |
                      (i_valid && ((i_probe.key & r_entry.keep) == r_entry.value));
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
        r_probe <= n_probe;
    end

    assign o_entry = r_entry;
    assign o_probe = r_probe;

endmodule

`default_nettype wire

// ===== sv/ipsm_ctrl.sv =====
`default_nettype none

module ipsm_ctrl (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_cmd,
    output logic            o_busy,
    output ipsm_pkg::t_ctl  o_ctl
);

    ipsm_pkg::t_state                  r_state;
    ipsm_pkg::t_state                  n_state;
    logic [ipsm_pkg::LOOK_W-1:0]       r_cnt;
    logic [ipsm_pkg::LOOK_W-1:0]       n_cnt;
    logic                              accept;

    assign accept = (r_state == ipsm_pkg::ST_IDLE) && i_start;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ipsm_pkg::ST_IDLE: begin
                if (accept && (i_cmd == ipsm_pkg::CMD_LOOKUP)) begin
                    n_state = ipsm_pkg::ST_LOOK;
                    n_cnt   = ipsm_pkg::LOOK_W'(ipsm_pkg::LOOK_CYCLES - 1);
                end
            end
            ipsm_pkg::ST_LOOK: begin
                if (r_cnt == '0) begin
                    n_state = ipsm_pkg::ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ipsm_pkg::ST_DONE: begin
                n_state = ipsm_pkg::ST_IDLE;
            end
            default: begin
                n_state = ipsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy         = (r_state != ipsm_pkg::ST_IDLE);
        o_ctl.add_net  = accept && (i_cmd == ipsm_pkg::CMD_ADD_NET);
        o_ctl.add_host = accept && (i_cmd == ipsm_pkg::CMD_ADD_HOST);
        o_ctl.imm_ack  = accept && (i_cmd != ipsm_pkg::CMD_LOOKUP);
        o_ctl.cap_net  = (r_state == ipsm_pkg::ST_LOOK) &&
                         (r_cnt == ipsm_pkg::LOOK_W'(ipsm_pkg::NET_CAP));
        o_ctl.cap_host = (r_state == ipsm_pkg::ST_LOOK) &&
                         (r_cnt == ipsm_pkg::LOOK_W'(ipsm_pkg::HOST_CAP));
        o_ctl.finish   = (r_state == ipsm_pkg::ST_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipsm_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ip_subnet_and_host_match_table.sv =====
`default_nettype none

// IPv4 subnet and host match table. Network entries (value, complemented
// mask) and host addresses sit in two shift chains of cells; a new entry
// enters at the head of its chain. A lookup key walks down both chains one
// cell per cycle, so the time a lookup takes is set by the length of the
// longer chain; busy stays high while it runs. Add commands and the unused
// command give their result beat in the next cycle and the block can take
// another command right away. An insert into a full table stores nothing
// and reports status 1. The result beat lasts one cycle and must be taken
// then: the receiver cannot stall it.
module ip_subnet_and_host_match_table (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire ipsm_pkg::t_in  i_data,
    output logic                o_strobe,
    output ipsm_pkg::t_out      o_result
);

    ipsm_pkg::t_ctl                      ctl;
    logic [ipsm_pkg::NET_CNT_W-1:0]      r_net_cnt;
    logic [ipsm_pkg::HOST_CNT_W-1:0]     r_host_cnt;
    logic                                net_full;
    logic                                host_full;
    logic                                net_shift;
    logic                                host_shift;
    logic                                r_net_hit;
    logic                                r_host_hit;
    logic                                r_strobe;
    ipsm_pkg::t_out                      r_result;
    ipsm_pkg::t_out                      n_result;

    ipsm_pkg::t_entry                    net_new;
    ipsm_pkg::t_entry                    host_new;
    ipsm_pkg::t_probe                    probe_head;
    ipsm_pkg::t_entry                    net_ent  [ipsm_pkg::NET_ENTRIES];
    ipsm_pkg::t_probe                    net_prb  [ipsm_pkg::NET_ENTRIES];
    ipsm_pkg::t_entry                    host_ent [ipsm_pkg::HOST_ENTRIES];
    ipsm_pkg::t_probe                    host_prb [ipsm_pkg::HOST_ENTRIES];

    ipsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_data.cmd),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    assign net_full   = (r_net_cnt == ipsm_pkg::NET_CNT_W'(ipsm_pkg::NET_ENTRIES));
    assign host_full  = (r_host_cnt == ipsm_pkg::HOST_CNT_W'(ipsm_pkg::HOST_ENTRIES));
    assign net_shift  = ctl.add_net && !net_full;
    assign host_shift = ctl.add_host && !host_full;

    assign net_new.value  = i_data.address;
    assign net_new.keep   = ~i_data.mask_bits;
    assign host_new.value = i_data.address;
    assign host_new.keep  = '1;
    assign probe_head.key = i_data.address;
    assign probe_head.hit = 1'b0;

    for (genvar gi = 0; gi < ipsm_pkg::NET_ENTRIES; gi++) begin : g_net
        ipsm_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (net_shift),
            .i_valid (r_net_cnt > ipsm_pkg::NET_CNT_W'(gi)),
            .i_entry ((gi == 0) ? net_new : net_ent[(gi == 0) ? 0 : gi - 1]),
            .o_entry (net_ent[gi]),
            .i_probe ((gi == 0) ? probe_head : net_prb[(gi == 0) ? 0 : gi - 1]),
            .o_probe (net_prb[gi])
        );
    end

    for (genvar gi = 0; gi < ipsm_pkg::HOST_ENTRIES; gi++) begin : g_host
        ipsm_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (host_shift),
            .i_valid (r_host_cnt > ipsm_pkg::HOST_CNT_W'(gi)),
            .i_entry ((gi == 0) ? host_new : host_ent[(gi == 0) ? 0 : gi - 1]),
            .o_entry (host_ent[gi]),
            .i_probe ((gi == 0) ? probe_head : host_prb[(gi == 0) ? 0 : gi - 1]),
            .o_probe (host_prb[gi])
        );
    end

    always_comb begin
        n_result = r_result;
        if (ctl.imm_ack) begin
            n_result.hit    = 1'b0;
            n_result.status = (ctl.add_net && net_full) || (ctl.add_host && host_full);
        end else if (ctl.finish) begin
            n_result.hit    = r_net_hit | r_host_hit;
            n_result.status = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_cnt  <= '0;
            r_host_cnt <= '0;
            r_strobe   <= 1'b0;
        end else begin
            if (net_shift) begin
                r_net_cnt <= r_net_cnt + 1'b1;
            end
            if (host_shift) begin
                r_host_cnt <= r_host_cnt + 1'b1;
            end
            r_strobe <= ctl.imm_ack | ctl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.cap_net) begin
            r_net_hit <= net_prb[ipsm_pkg::NET_ENTRIES-1].hit;
        end
        if (ctl.cap_host) begin
            r_host_hit <= host_prb[ipsm_pkg::HOST_ENTRIES-1].hit;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire
